### sv/skpf_pkg.sv
// Package for the scalar Kalman pressure filter core.
// Holds the register indexes and the sequencer state type; no dependencies.
`default_nettype none

package skpf_pkg;

  localparam int CFG_IDX_BITS = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_PROCESS_NOISE     = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MEASUREMENT_NOISE = 1'b1;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_PRED   = 8'b0000_0010,
    ST_DENOM  = 8'b0000_0100,
    ST_DIV    = 8'b0000_1000,
    ST_TAIL   = 8'b0001_0000,
    ST_ROUND  = 8'b0010_0000,
    ST_UPDATE = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_e;

endpackage

`default_nettype wire

### sv/scalar_kalman_pressure_filter_core.sv
// Scalar Kalman filter core for barometric pressure samples.
// Depends on skpf_pkg for register indexes and the state type.
// An item with history runs through the restoring divider that forms the gain one quotient bit
// per cycle while two shift-and-add multipliers consume each bit in the cycle after it is
// formed; a sample with no stored estimate goes straight to the final state and passes through
// unchanged. One item is in work at a time, and a finished result waits in the output register
// while the next sample is taken.
`default_nettype none

module scalar_kalman_pressure_filter_core #(
  parameter int FRAC_BITS     = 16,
  parameter int PRESSURE_BITS = 17
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output      logic                               in_stall_o,
  input  wire logic [PRESSURE_BITS-1:0]           pressure_sample_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_stall_i,
  output      logic [PRESSURE_BITS-1:0]           filtered_pressure_o,
  input  wire logic                               cfg_valid_i,
  output      logic                               cfg_ready_o,
  input  wire logic [skpf_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire logic [FRAC_BITS+7:0]               cfg_data_i
);

  localparam int VB = FRAC_BITS + 8;
  localparam int PB = PRESSURE_BITS;
  localparam int NB = VB + FRAC_BITS + 1;
  localparam int MB = PB + FRAC_BITS + 1;
  localparam int CW = $clog2(FRAC_BITS + 1);

  localparam logic [VB-1:0] Q_RESET   = VB'(1) << (FRAC_BITS - 1);
  localparam logic [VB-1:0] R_RESET   = VB'(64) << FRAC_BITS;
  localparam logic [VB-1:0] VAR_RESET = VB'(1) << FRAC_BITS;
  localparam logic [NB-1:0] HALF_N    = NB'(1) << (FRAC_BITS - 1);
  localparam logic [MB-1:0] HALF_M    = MB'(1) << (FRAC_BITS - 1);
  localparam logic [CW-1:0] CNT_LAST  = CW'(FRAC_BITS);

  skpf_pkg::state_e state_q, state_d;

  logic [VB-1:0]        q_noise_q, r_noise_q;
  logic [PB-1:0]        last_q;
  logic [VB-1:0]        var_q;
  logic                 out_valid_q;
  logic [CW-1:0]        cnt_q;

  logic [PB-1:0]        sample_q, mag_q, est_q, out_q;
  logic                 up_q, den_zero_q, bit_q;
  logic [VB-1:0]        pred_q, varn_q;
  logic [VB:0]          den_q, rem_q;
  logic [FRAC_BITS:0]   num_q;
  logic [MB-1:0]        accm_q;
  logic [NB-1:0]        accp_q;
  logic [PB:0]          corr_q;

  logic                 in_xfer, out_free;
  logic [VB:0]          pred_sum, den_sum;
  logic [VB-1:0]        pred_sat;
  logic [NB-1:0]        numer, vsum;
  logic [VB+1:0]        trial, diff;
  logic                 qbit;
  logic [VB:0]          rem_d;
  logic [MB-1:0]        accm_d, corr_sum;
  logic [NB-1:0]        accp_d;
  logic [PB+1:0]        lsum;
  logic [PB-1:0]        est_d;

  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != skpf_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign filtered_pressure_o = out_q;
  assign cfg_ready_o = 1'b1;

  assign pred_sum = {1'b0, var_q} + {1'b0, q_noise_q};
  assign pred_sat = pred_sum[VB] ? {VB{1'b1}} : pred_sum[VB-1:0];
  assign den_sum  = {1'b0, pred_q} + {1'b0, r_noise_q};
  assign numer    = {1'b0, pred_q, {FRAC_BITS{1'b0}}} + NB'(den_sum[VB:1]);

  assign trial = {rem_q, num_q[FRAC_BITS]};
  assign diff  = trial - {1'b0, den_q};
  assign qbit  = !den_zero_q && (trial >= {1'b0, den_q});
  assign rem_d = qbit ? diff[VB:0] : trial[VB:0];

  assign accm_d = {accm_q[MB-2:0], 1'b0} + (bit_q ? MB'(mag_q) : '0);
  assign accp_d = {accp_q[NB-2:0], 1'b0} + (bit_q ? NB'(pred_q) : '0);

  assign corr_sum = accm_q + HALF_M;
  assign vsum     = {1'b0, pred_q, {FRAC_BITS{1'b0}}} - accp_q + HALF_N;

  assign lsum = (PB+2)'(last_q) + (PB+2)'(corr_q);

  always_comb begin
    if (up_q) begin
      est_d = (lsum[PB+1:PB] != 2'b00) ? {PB{1'b1}} : lsum[PB-1:0];
    end else begin
      est_d = (corr_q >= {1'b0, last_q}) ? '0 : last_q - corr_q[PB-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      skpf_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = (last_q == '0) ? skpf_pkg::ST_DONE : skpf_pkg::ST_PRED;
        end
      end
      skpf_pkg::ST_PRED:   state_d = skpf_pkg::ST_DENOM;
      skpf_pkg::ST_DENOM:  state_d = skpf_pkg::ST_DIV;
      skpf_pkg::ST_DIV: begin
        if (cnt_q == CNT_LAST) begin
          state_d = skpf_pkg::ST_TAIL;
        end
      end
      skpf_pkg::ST_TAIL:   state_d = skpf_pkg::ST_ROUND;
      skpf_pkg::ST_ROUND:  state_d = skpf_pkg::ST_UPDATE;
      skpf_pkg::ST_UPDATE: state_d = skpf_pkg::ST_DONE;
      skpf_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = skpf_pkg::ST_IDLE;
        end
      end
      default: state_d = skpf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= skpf_pkg::ST_IDLE;
      q_noise_q   <= Q_RESET;
      r_noise_q   <= R_RESET;
      last_q      <= '0;
      var_q       <= VAR_RESET;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          skpf_pkg::REG_PROCESS_NOISE:     q_noise_q <= cfg_data_i;
          skpf_pkg::REG_MEASUREMENT_NOISE: r_noise_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == skpf_pkg::ST_DENOM) begin
        cnt_q <= '0;
      end else if (state_q == skpf_pkg::ST_DIV) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (state_q == skpf_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
        last_q      <= est_q;
        var_q       <= varn_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      skpf_pkg::ST_IDLE: begin
        if (in_xfer) begin
          sample_q <= pressure_sample_i;
          est_q    <= pressure_sample_i;
          varn_q   <= var_q;
        end
      end
      skpf_pkg::ST_PRED: begin
        pred_q <= pred_sat;
        up_q   <= (sample_q >= last_q);
        mag_q  <= (sample_q >= last_q) ? sample_q - last_q : last_q - sample_q;
      end
      skpf_pkg::ST_DENOM: begin
        den_q      <= den_sum;
        den_zero_q <= (den_sum == '0);
        rem_q      <= {1'b0, numer[NB-1:FRAC_BITS+1]};
        num_q      <= numer[FRAC_BITS:0];
        accm_q     <= '0;
        accp_q     <= '0;
        bit_q      <= 1'b0;
      end
      skpf_pkg::ST_DIV: begin
        rem_q  <= rem_d;
        num_q  <= {num_q[FRAC_BITS-1:0], 1'b0};
        accm_q <= accm_d;
        accp_q <= accp_d;
        bit_q  <= qbit;
      end
      skpf_pkg::ST_TAIL: begin
        accm_q <= accm_d;
        accp_q <= accp_d;
      end
      skpf_pkg::ST_ROUND: begin
        corr_q <= corr_sum[MB-1:FRAC_BITS];
        varn_q <= vsum[NB-2:FRAC_BITS];
      end
      skpf_pkg::ST_UPDATE: begin
        est_q <= est_d;
      end
      skpf_pkg::ST_DONE: begin
        if (out_free) begin
          out_q <= est_q;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == skpf_pkg::ST_DIV) |-> (den_zero_q || (rem_q < den_q)))
    else $error("divider remainder not below divisor");

  a_variance_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == skpf_pkg::ST_UPDATE) |-> (varn_q <= pred_q))
    else $error("updated variance exceeds predicted variance");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == skpf_pkg::ST_DONE))
    else $error("result raised outside the final state");
`endif

endmodule

`default_nettype wire
